// ----- sv/bfgs_pkg.sv -----
// Shared constants for the Brownian force sampler.
`timescale 1ns / 1ps
package bfgs_pkg;

  localparam int SAMPLE_W = 24;
  localparam int DIAM_W   = 16;
  localparam int TEMP_W   = 24;
  localparam int VISC_W   = 32;
  localparam int DT_W     = 32;
  localparam int FORCE_W  = 32;
  localparam int MAX_AXES = 3;

  // ln2 in Q24, 1/a in Q24, 2/(pi a) in Q28, 6 pi kB 1e24 in Q24
  localparam logic [23:0] LN2_Q24     = 24'd11629080;
  localparam logic [26:0] INV_A_Q24   = 27'd114130721;
  localparam logic [30:0] K0_Q28      = 31'd1162525979;
  localparam logic [32:0] FORCE_K_Q24 = 33'd4366206800;

  localparam logic [FORCE_W-1:0] FORCE_MIN = 32'h8000_0000;
  localparam logic [FORCE_W-1:0] FORCE_MAX = 32'h7fff_ffff;

endpackage

// ----- sv/bfgs_if.sv -----
// Particle input and force output channel interfaces.
`timescale 1ns / 1ps
interface bfgs_in_if;
  logic                            valid;
  logic                            ready;
  logic [bfgs_pkg::SAMPLE_W-1:0]   uniform_x;
  logic [bfgs_pkg::SAMPLE_W-1:0]   uniform_y;
  logic [bfgs_pkg::SAMPLE_W-1:0]   uniform_z;
  logic [bfgs_pkg::DIAM_W-1:0]     diameter_nm;
  logic [bfgs_pkg::TEMP_W-1:0]     temperature_mk;
  logic [bfgs_pkg::VISC_W-1:0]     viscosity_npas;
  logic [bfgs_pkg::DT_W-1:0]       timestep_ns;

  modport source (output valid, uniform_x, uniform_y, uniform_z, diameter_nm,
                  temperature_mk, viscosity_npas, timestep_ns, input ready);
  modport sink (input valid, uniform_x, uniform_y, uniform_z, diameter_nm,
                temperature_mk, viscosity_npas, timestep_ns, output ready);
endinterface

interface bfgs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bfgs_pkg::FORCE_W-1:0] force_x;
  logic signed [bfgs_pkg::FORCE_W-1:0] force_y;
  logic signed [bfgs_pkg::FORCE_W-1:0] force_z;
  logic                               saturated;

  modport source (output valid, force_x, force_y, force_z, saturated, input ready);
  modport sink (input valid, force_x, force_y, force_z, saturated, output ready);
endinterface

// ----- sv/brownian_force_gaussian_sampler_unit.sv -----
// Throughput: one particle word per cycle unless the output stalls; set by the
// bit-per-stage divider and square-root pipelines, which all advance together.
// A stall at the output holds every stage; input ready follows the output side.
// Reset clears the stage valid bits only; the datapath registers are not reset.
`timescale 1ns / 1ps
module brownian_force_gaussian_sampler_unit #(
  parameter int SAMPLE_BITS = 24,
  parameter int AXES        = 3
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bfgs_in_if.sink  in_i,
  bfgs_out_if.source out_o
);

  localparam int S        = SAMPLE_BITS;
  localparam int LW       = (2*S-1 > 32) ? 2*S-1 : 32;
  localparam int NSH      = $clog2(LW);
  localparam int FR_W     = 32;
  localparam int LOGW     = NSH + FR_W;
  localparam int KW       = LOGW - 3;
  localparam int AKW      = LOGW - 4;
  localparam int K_SH     = 5;
  localparam int ROOT_W   = 32;
  localparam int DIV_SH   = 29;
  localparam int DIV_NW   = 64 + DIV_SH;
  localparam int DV_W     = ROOT_W + 1;
  localparam int SS_W     = 2 + KW + AKW + 64;
  localparam int DS_W     = 2 + 1 + 64;
  localparam int MT_W     = bfgs_pkg::VISC_W + bfgs_pkg::TEMP_W;
  localparam int P_W      = MT_W + bfgs_pkg::DIAM_W;
  localparam int P_LO     = P_W / 2;
  localparam int PK_W     = P_W - P_LO + 33;
  localparam int Q_W      = P_W + 33;
  localparam int F_SH     = 8;
  localparam int FNUM_W   = Q_W + F_SH;
  localparam int FQ_W     = (FNUM_W + 1) / 2;
  localparam int FQ_LO    = FQ_W / 2;
  localparam int RW       = FQ_W + ROOT_W + 1;
  localparam int RND_SH   = 44;
  localparam int VW       = RW - RND_SH;
  localparam int ETA_LAT  = 1 + NSH + FR_W + 5 + ROOT_W + 1 + DIV_NW + 1 + ROOT_W;
  localparam int F_LAT    = 4 + FNUM_W + FQ_W;
  localparam int DLY      = ETA_LAT - F_LAT;
  localparam int LAT      = ETA_LAT + 3;
  localparam logic [S:0]      FULL = (S+1)'(1) << S;
  localparam logic [LOGW-1:0] TOPV = LOGW'(2*S-2) << FR_W;

  logic                               adv;
  logic [LAT-1:0]                     vld_q;
  logic [bfgs_pkg::SAMPLE_W-1:0]      smp [bfgs_pkg::MAX_AXES];
  logic signed [bfgs_pkg::FORCE_W-1:0] lane_frc [bfgs_pkg::MAX_AXES];
  logic                               lane_sat [bfgs_pkg::MAX_AXES];
  logic signed [bfgs_pkg::FORCE_W-1:0] frc_q [bfgs_pkg::MAX_AXES];
  logic                               sat_q;
  logic [MT_W-1:0]                    mt_q;
  logic [P_W-1:0]                     p_q;
  logic [PK_W-1:0]                    pl_q;
  logic [PK_W-1:0]                    ph_q;
  logic [Q_W-1:0]                     q_q;
  logic [bfgs_pkg::DIAM_W-1:0]        d1_q;
  logic [bfgs_pkg::DT_W-1:0]          dt1_q;
  logic [bfgs_pkg::DT_W-1:0]          dt2_q;
  logic [bfgs_pkg::DT_W-1:0]          dt3_q;
  logic [bfgs_pkg::DT_W-1:0]          dt4_q;
  logic [FNUM_W-1:0]                  fquo;
  logic [FQ_W-1:0]                    fq;
  logic [FQ_W-1:0]                    fq_dl_q [DLY];

  assign adv         = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready  = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  assign smp[0] = in_i.uniform_x;
  assign smp[1] = in_i.uniform_y;
  assign smp[2] = in_i.uniform_z;

  // force scale f^2 = K mu T d / dt
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mt_q  <= MT_W'(in_i.viscosity_npas) * MT_W'(in_i.temperature_mk);
      d1_q  <= in_i.diameter_nm;
      dt1_q <= (in_i.timestep_ns == '0) ? bfgs_pkg::DT_W'(1) : in_i.timestep_ns;
      p_q   <= P_W'(mt_q) * P_W'(d1_q);
      dt2_q <= dt1_q;
      pl_q  <= PK_W'(p_q[P_LO-1:0]) * PK_W'(bfgs_pkg::FORCE_K_Q24);
      ph_q  <= PK_W'(p_q[P_W-1:P_LO]) * PK_W'(bfgs_pkg::FORCE_K_Q24);
      dt3_q <= dt2_q;
      q_q   <= Q_W'(pl_q) + (Q_W'(ph_q) << P_LO);
      dt4_q <= dt3_q;
    end
  end

  bfgs_div #(.NW(FNUM_W), .DW(bfgs_pkg::DT_W), .QW(FNUM_W), .SW(1)) u_fdiv (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .num_i  ({q_q, {F_SH{1'b0}}}),
    .den_i  (dt4_q),
    .side_i (1'b0),
    .quo_o  (fquo),
    .side_o ()
  );

  bfgs_isqrt #(.NW(FQ_W), .SW(1)) u_fsqrt (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .rad_i  ((2*FQ_W)'(fquo)),
    .side_i (1'b0),
    .root_o (fq),
    .side_o ()
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fq_dl_q[0] <= fq;
      for (int i = 1; i < DLY; i++) begin
        fq_dl_q[i] <= fq_dl_q[i-1];
      end
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_ax
    logic [S-1:0]        m;
    logic [S:0]          mc;
    logic [2*S:0]        wp;
    logic [LW-1:0]       w_q;
    logic [1:0]          fw_q;
    logic [LW-1:0]       nw_q [NSH];
    logic [NSH-1:0]      lz_q [NSH];
    logic [1:0]          fn_q [NSH];
    logic [FR_W-1:0]     z_q  [FR_W];
    logic [FR_W-1:0]     fr_q [FR_W];
    logic [NSH-1:0]      ex_q [FR_W];
    logic [1:0]          fs_q [FR_W];
    logic [LOGW-1:0]     lg;
    logic [LOGW-1:0]     negl2_q;
    logic [LOGW+23:0]    nlp;
    logic [LOGW-1:0]     negl_q;
    logic [LOGW+26:0]    nhp;
    logic [63:0]         negh_q;
    logic signed [KW-1:0] k_q;
    logic [AKW-1:0]      ak;
    logic [63:0]         ak2_q;
    logic [63:0]         nhd_q;
    logic signed [KW-1:0] kd_q;
    logic [AKW-1:0]      akd_q;
    logic [63:0]         ds_q;
    logic [SS_W-1:0]     se_q;
    logic [1:0]          fa_q;
    logic [1:0]          fb_q;
    logic [1:0]          fc_q;
    logic [1:0]          fd_q;
    logic [ROOT_W-1:0]   s;
    logic [SS_W-1:0]     ss_side;
    logic [1:0]          fl_s;
    logic [KW-1:0]       kk;
    logic [AKW-1:0]      akk;
    logic [63:0]         nhh;
    logic [63:0]         sak;
    logic                kpos;
    logic [DIV_NW-1:0]   num_q;
    logic [DV_W-1:0]     dv_q;
    logic [DS_W-1:0]     dsd_q;
    logic [63:0]         quo;
    logic [DS_W-1:0]     ds_side;
    logic [63:0]         tt_q;
    logic [1:0]          ft_q;
    logic [ROOT_W-1:0]   eta;
    logic [1:0]          fe;
    logic [FQ_LO+ROOT_W-1:0]      pl_m_q;
    logic [FQ_W-FQ_LO+ROOT_W-1:0] ph_m_q;
    logic [1:0]          fm_q;
    logic [RW-1:0]       rnd_q;
    logic [1:0]          fr2_q;
    logic [VW-1:0]       val;
    logic                ovf;
    logic [bfgs_pkg::FORCE_W-1:0] mag;

    // flags: {sample is zero, sample below one half}
    assign m  = S'(smp[g]);
    assign mc = FULL - (S+1)'(m);
    assign wp = (2*S+1)'(m) * (2*S+1)'(mc);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        w_q  <= LW'(wp);
        fw_q <= {m == '0, !m[S-1]};
      end
    end

    // leading-one search, one shift distance per stage
    for (genvar j = 0; j < NSH; j++) begin : g_lz
      localparam int A = 1 << (NSH - 1 - j);
      logic [LW-1:0]  x_in;
      logic [NSH-1:0] c_in;
      logic [1:0]     f_in;
      logic           hz;

      if (j == 0) begin : g_first
        assign x_in = w_q;
        assign c_in = '0;
        assign f_in = fw_q;
      end else begin : g_next
        assign x_in = nw_q[j-1];
        assign c_in = lz_q[j-1];
        assign f_in = fn_q[j-1];
      end

      assign hz = x_in[LW-1 -: A] == '0;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          nw_q[j] <= hz ? x_in << A : x_in;
          lz_q[j] <= hz ? c_in + NSH'(A) : c_in;
          fn_q[j] <= f_in;
        end
      end
    end

    // log2 fraction bits by repeated squaring of the Q1.31 mantissa
    for (genvar i = 0; i < FR_W; i++) begin : g_sq
      logic [FR_W-1:0] z_in;
      logic [FR_W-1:0] r_in;
      logic [NSH-1:0]  e_in;
      logic [1:0]      f_in;
      logic [63:0]     sq;
      logic            ov;

      if (i == 0) begin : g_first
        assign z_in = nw_q[NSH-1][LW-1 -: FR_W];
        assign r_in = '0;
        assign e_in = NSH'(LW-1) - lz_q[NSH-1];
        assign f_in = fn_q[NSH-1];
      end else begin : g_next
        assign z_in = z_q[i-1];
        assign r_in = fr_q[i-1];
        assign e_in = ex_q[i-1];
        assign f_in = fs_q[i-1];
      end

      assign sq = 64'(z_in) * 64'(z_in);
      assign ov = sq[63];

      always_ff @(posedge clk_i) begin
        if (adv) begin
          z_q[i]  <= ov ? sq[63:32] : sq[62:31];
          fr_q[i] <= {r_in[FR_W-2:0], ov};
          ex_q[i] <= e_in;
          fs_q[i] <= f_in;
        end
      end
    end

    assign lg  = {ex_q[FR_W-1], fr_q[FR_W-1]};
    assign nlp = (LOGW+24)'(negl2_q) * (LOGW+24)'(bfgs_pkg::LN2_Q24);
    assign nhp = (LOGW+27)'(negl_q) * (LOGW+27)'(bfgs_pkg::INV_A_Q24);
    assign ak  = k_q[KW-1] ? AKW'(-k_q) : AKW'(k_q);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        negl2_q <= (TOPV > lg) ? TOPV - lg : '0;
        fa_q    <= fs_q[FR_W-1];
        negl_q  <= nlp[LOGW+23:24];
        fb_q    <= fa_q;
        negh_q  <= 64'(nhp);
        k_q     <= $signed(KW'(bfgs_pkg::K0_Q28)) - $signed(KW'(negl_q >> K_SH));
        fc_q    <= fb_q;
        ak2_q   <= 64'((2*AKW)'(ak) * (2*AKW)'(ak));
        nhd_q   <= negh_q;
        kd_q    <= k_q;
        akd_q   <= ak;
        fd_q    <= fc_q;
        ds_q    <= ak2_q + nhd_q;
        se_q    <= {fd_q, kd_q, akd_q, nhd_q};
      end
    end

    bfgs_isqrt #(.NW(ROOT_W), .SW(SS_W)) u_ssqrt (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .rad_i  (ds_q),
      .side_i (se_q),
      .root_o (s),
      .side_o (ss_side)
    );

    assign fl_s = ss_side[SS_W-1 -: 2];
    assign kk   = ss_side[SS_W-3 -: KW];
    assign akk  = ss_side[AKW+63 -: AKW];
    assign nhh  = ss_side[63:0];
    assign kpos = !kk[KW-1] && (kk != '0);
    assign sak  = 64'(s) + 64'(akk);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        num_q <= {nhh, {DIV_SH{1'b0}}};
        dv_q  <= DV_W'(s) + DV_W'(kk);
        dsd_q <= {fl_s, kpos, sak << DIV_SH};
      end
    end

    bfgs_div #(.NW(DIV_NW), .DW(DV_W), .QW(64), .SW(DS_W)) u_div (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .num_i  (num_q),
      .den_i  (dv_q),
      .side_i (dsd_q),
      .quo_o  (quo),
      .side_o (ds_side)
    );

    always_ff @(posedge clk_i) begin
      if (adv) begin
        tt_q <= ds_side[64] ? quo : ds_side[63:0];
        ft_q <= ds_side[DS_W-1 -: 2];
      end
    end

    bfgs_isqrt #(.NW(ROOT_W), .SW(2)) u_esqrt (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .rad_i  (tt_q),
      .side_i (ft_q),
      .root_o (eta),
      .side_o (fe)
    );

    // f * eta in two partial products, then round half up
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pl_m_q <= (FQ_LO+ROOT_W)'(fq_dl_q[DLY-1][FQ_LO-1:0]) * (FQ_LO+ROOT_W)'(eta);
        ph_m_q <= (FQ_W-FQ_LO+ROOT_W)'(fq_dl_q[DLY-1][FQ_W-1:FQ_LO])
                  * (FQ_W-FQ_LO+ROOT_W)'(eta);
        fm_q   <= fe;
        rnd_q  <= RW'(pl_m_q) + (RW'(ph_m_q) << FQ_LO) + (RW'(1) << (RND_SH-1));
        fr2_q  <= fm_q;
      end
    end

    assign val = rnd_q[RW-1:RND_SH];
    assign ovf = fr2_q[0] ? (val > VW'(bfgs_pkg::FORCE_MIN))
                          : (val > VW'(bfgs_pkg::FORCE_MAX));
    assign mag = ovf ? (fr2_q[0] ? bfgs_pkg::FORCE_MIN : bfgs_pkg::FORCE_MAX)
                     : val[bfgs_pkg::FORCE_W-1:0];

    always_comb begin
      if (fr2_q[1]) begin
        lane_frc[g] = $signed(bfgs_pkg::FORCE_MIN);
        lane_sat[g] = 1'b1;
      end else begin
        lane_frc[g] = fr2_q[0] ? $signed(bfgs_pkg::FORCE_W'(0) - mag) : $signed(mag);
        lane_sat[g] = ovf;
      end
    end
  end

  for (genvar g = AXES; g < bfgs_pkg::MAX_AXES; g++) begin : g_unused
    assign lane_frc[g] = '0;
    assign lane_sat[g] = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      frc_q <= lane_frc;
      sat_q <= lane_sat[0] | lane_sat[1] | lane_sat[2];
    end
  end

  assign out_o.valid     = vld_q[LAT-1];
  assign out_o.force_x   = frc_q[0];
  assign out_o.force_y   = frc_q[1];
  assign out_o.force_z   = frc_q[2];
  assign out_o.saturated = sat_q;

  a_in_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted word missing from first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q == $past(vld_q))
    else $error("pipeline valid bits moved during stall");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !vld_q[LAT-2] |=> !out_o.valid)
    else $error("output word repeated");

endmodule

// ----- sv/bfgs_isqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module bfgs_isqrt #(
  parameter int NW = 32,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            adv_i,
  input  logic [2*NW-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic [NW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  logic [NW:0]     rem_q  [NW];
  logic [NW-1:0]   root_q [NW];
  logic [2*NW-1:0] rad_q  [NW];
  logic [SW-1:0]   sd_q   [NW];

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [NW:0]     r_in;
    logic [NW-1:0]   q_in;
    logic [2*NW-1:0] x_in;
    logic [SW-1:0]   s_in;
    logic [NW+2:0]   r_sh;
    logic [NW+2:0]   trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign x_in = rad_i;
      assign s_in = side_i;
    end else begin : g_next
      assign r_in = rem_q[i-1];
      assign q_in = root_q[i-1];
      assign x_in = rad_q[i-1];
      assign s_in = sd_q[i-1];
    end

    assign r_sh  = {r_in, x_in[2*NW-1:2*NW-2]};
    assign trial = {1'b0, q_in, 2'b01};
    assign ge    = r_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[i]  <= ge ? (NW+1)'(r_sh - trial) : (NW+1)'(r_sh);
        root_q[i] <= {q_in[NW-2:0], ge};
        rad_q[i]  <= x_in << 2;
        sd_q[i]   <= s_in;
      end
    end
  end

  assign root_o = root_q[NW-1];
  assign side_o = sd_q[NW-1];

endmodule

// ----- sv/bfgs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bfgs_div #(
  parameter int NW = 93,
  parameter int DW = 33,
  parameter int QW = 64,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          adv_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] wrd_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [SW-1:0] sd_q  [NW];

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW-1:0] r_in;
    logic [NW-1:0] w_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   r_sh;
    logic          ge;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign w_in = num_i;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_next
      assign r_in = rem_q[i-1];
      assign w_in = wrd_q[i-1];
      assign d_in = den_q[i-1];
      assign s_in = sd_q[i-1];
    end

    assign r_sh = {r_in, w_in[NW-1]};
    assign ge   = r_sh >= {1'b0, d_in};

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[i] <= ge ? DW'(r_sh - {1'b0, d_in}) : DW'(r_sh);
        wrd_q[i] <= {w_in[NW-2:0], ge};
        den_q[i] <= d_in;
        sd_q[i]  <= s_in;
      end
    end
  end

  assign quo_o  = wrd_q[NW-1][QW-1:0];
  assign side_o = sd_q[NW-1];

endmodule

// ----- dv/bfgs_force_checker.sv -----
// Force predictor and scoreboard watching the particle and force channels.
`timescale 1ns / 1ps
module bfgs_force_checker
  import bfgs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bfgs_in_if         in_i,
  bfgs_out_if        out_i,
  output int         errors_o,
  output int         pending_o,
  output int         checked_o,
  output int         saturated_o
);

  typedef struct packed {
    logic [FORCE_W-1:0] fx;
    logic [FORCE_W-1:0] fy;
    logic [FORCE_W-1:0] fz;
    logic               sat;
  } force_t;

  force_t forces_q[$];

  function automatic logic [63:0] isqrt_u128(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] log2_q32(input logic [63:0] w);
    int          e;
    logic [63:0] z;
    logic [63:0] frac;
    e    = 63;
    frac = '0;
    while (!w[e]) e--;
    z = (e >= 31) ? (w >> (e - 31)) : (w << (31 - e));
    for (int i = 0; i < 32; i++) begin
      z    = (z * z) >> 31;
      frac = frac << 1;
      if (z >= 64'h1_0000_0000) begin
        z       = z >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e) << 32) + frac;
  endfunction

  function automatic logic [63:0] gauss_mag_q28(input logic [63:0] m);
    logic [63:0]  w, top, lg, negl2, negl, negh, ak, s, two_t;
    logic [127:0] num;
    longint       k;
    w     = m * ((64'd1 << SAMPLE_W) - m);
    top   = 64'(2 * SAMPLE_W - 2) << 32;
    lg    = log2_q32(w);
    negl2 = (top > lg) ? top - lg : 64'd0;
    negl  = (negl2 * 64'(LN2_Q24)) >> 24;
    negh  = negl * 64'(INV_A_Q24);
    k     = longint'(K0_Q28) - longint'(negl >> 5);
    ak    = (k < 0) ? 64'(-k) : 64'(k);
    s     = isqrt_u128({64'd0, ak * ak + negh});
    if (k > 0) begin
      num   = {64'd0, negh} << 29;
      two_t = 64'(num / {64'd0, s + 64'(k)});
    end else begin
      two_t = (s + ak) << 29;
    end
    return isqrt_u128({64'd0, two_t});
  endfunction

  function automatic force_t predict_force(
    input logic [SAMPLE_W-1:0] ux, uy, uz,
    input logic [DIAM_W-1:0]   d,
    input logic [TEMP_W-1:0]   t,
    input logic [VISC_W-1:0]   mu,
    input logic [DT_W-1:0]     dt_in
  );
    logic [127:0]        p, num, prod, full;
    logic [63:0]         dt, fq, m;
    logic [FORCE_W-1:0]  comp[3];
    logic                neg;
    force_t              r;
    dt   = (dt_in == 0) ? 64'd1 : 64'(dt_in);
    p    = {64'd0, 64'(mu) * 64'(t)} * 128'(d);
    num  = (p * 128'(FORCE_K_Q24)) << 8;
    fq   = isqrt_u128(num / {64'd0, dt});
    r.sat = 1'b0;
    for (int a = 0; a < 3; a++) begin
      m = (a == 0) ? 64'(ux) : (a == 1) ? 64'(uy) : 64'(uz);
      comp[a] = '0;
      if (m == 0) begin
        comp[a] = FORCE_MIN;
        r.sat   = 1'b1;
      end else begin
        neg  = m < (64'd1 << (SAMPLE_W - 1));
        prod = {64'd0, fq} * {64'd0, gauss_mag_q28(m)};
        full = (prod + (128'd1 << 43)) >> 44;
        if (neg) begin
          if (full > 128'h8000_0000) begin
            full  = 128'h8000_0000;
            r.sat = 1'b1;
          end
          comp[a] = FORCE_W'(-full[31:0]);
        end else begin
          if (full > 128'h7fff_ffff) begin
            full  = 128'h7fff_ffff;
            r.sat = 1'b1;
          end
          comp[a] = full[31:0];
        end
      end
    end
    r.fx = comp[0];
    r.fy = comp[1];
    r.fz = comp[2];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
    $display("force mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    errors_o++;
  endtask

  initial begin
    errors_o    = 0;
    checked_o   = 0;
    saturated_o = 0;
  end

  assign pending_o = forces_q.size();

  always @(posedge clk_i) begin
    force_t exp_f;
    if (rst_ni && in_i.valid && in_i.ready)
      forces_q.push_back(predict_force(in_i.uniform_x, in_i.uniform_y, in_i.uniform_z,
                                       in_i.diameter_nm, in_i.temperature_mk,
                                       in_i.viscosity_npas, in_i.timestep_ns));
    if (rst_ni && out_i.valid && out_i.ready) begin
      if (forces_q.size() == 0) begin
        report_mismatch("unexpected word", out_i.force_x, '0);
      end else begin
        exp_f = forces_q.pop_front();
        checked_o++;
        if (exp_f.sat) saturated_o++;
        if (out_i.force_x !== exp_f.fx) report_mismatch("force_x", out_i.force_x, exp_f.fx);
        if (out_i.force_y !== exp_f.fy) report_mismatch("force_y", out_i.force_y, exp_f.fy);
        if (out_i.force_z !== exp_f.fz) report_mismatch("force_z", out_i.force_z, exp_f.fz);
        if (out_i.saturated !== exp_f.sat)
          report_mismatch("saturated", 32'(out_i.saturated), 32'(exp_f.sat));
      end
    end
  end

endmodule

// ----- dv/brownian_force_gaussian_sampler_unit_tb.sv -----
// Top-level testbench: particle stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
module brownian_force_gaussian_sampler_unit_tb;
  import bfgs_pkg::*;

  localparam int N_RANDOM   = 1800;
  localparam int DRAIN_CYC  = 260;
  localparam int CYCLE_LIM  = 200000;

  logic clk_i;
  logic rst_ni;
  int   errors, pending, checked, n_sat;
  int   sent;
  int   cycles;

  bfgs_in_if  in_ch();
  bfgs_out_if out_ch();

  brownian_force_gaussian_sampler_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  bfgs_force_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .saturated_o (n_sat)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rand_bits(input int w);
    int n;
    n = $urandom_range(w, 1);
    return $urandom & ((n >= 32) ? 32'hffff_ffff : ((32'd1 << n) - 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return SAMPLE_W'($urandom_range(3, 1));
      2:       return {SAMPLE_W{1'b1}} - SAMPLE_W'($urandom_range(3, 0));
      3:       return (SAMPLE_W'(1) << (SAMPLE_W - 1)) + SAMPLE_W'($urandom_range(3, 0))
                      - SAMPLE_W'(2);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // send one particle word; gap drawn unless in a burst stretch
  task automatic send_particle(input logic [SAMPLE_W-1:0] ux, uy, uz,
                               input logic [DIAM_W-1:0] d, input logic [TEMP_W-1:0] t,
                               input logic [VISC_W-1:0] mu, input logic [DT_W-1:0] dt);
    int gap;
    gap = ((sent / 150) % 3 == 2) ? 0 : $urandom_range(6, 0);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.uniform_x      = ux;
    in_ch.uniform_y      = uy;
    in_ch.uniform_z      = uz;
    in_ch.diameter_nm    = d;
    in_ch.temperature_mk = t;
    in_ch.viscosity_npas = mu;
    in_ch.timestep_ns    = dt;
    in_ch.valid          = 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] s_mid, s_max;
    s_mid = SAMPLE_W'(1) << (SAMPLE_W - 1);
    s_max = {SAMPLE_W{1'b1}};
    sent = 0;
    in_ch.valid = 1'b0;
    in_ch.uniform_x = '0;
    in_ch.uniform_y = '0;
    in_ch.uniform_z = '0;
    in_ch.diameter_nm = '0;
    in_ch.temperature_mk = '0;
    in_ch.viscosity_npas = '0;
    in_ch.timestep_ns = '0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // directed: sample edges, zero sample, zero and huge scale, dt extremes
    send_particle('0, 24'd1, s_max, 16'd100, 24'd300000, 32'd1000000, 32'd1000);
    send_particle(s_mid, s_mid - 24'd1, s_mid + 24'd1, 16'd100, 24'd300000, 32'd1000000,
                  32'd1000);
    send_particle(24'd2, s_max - 24'd1, 24'd12345, 16'd1, 24'd1, 32'd1, 32'hffff_ffff);
    send_particle('0, '0, '0, 16'd1, 24'd0, 32'd0, 32'd1);
    send_particle(24'd1, s_max, s_mid, 16'hffff, 24'hffffff, 32'hffff_ffff, 32'd1);
    send_particle(s_max, 24'd1, '0, 16'hffff, 24'hffffff, 32'hffff_ffff, 32'hffff_ffff);
    send_particle(24'h555555, 24'haaaaaa, 24'h0f0f0f, 16'h5555, 24'haaaaaa, 32'h55555555,
                  32'haaaaaaaa);
    send_particle(24'haaaaaa, 24'h555555, 24'hf0f0f0, 16'haaaa, 24'h555555, 32'haaaaaaaa,
                  32'h55555555);
    send_particle(24'h400000, 24'hc00000, 24'h7fffff, 16'd1000, 24'd293000, 32'd890000,
                  32'd0);
    send_particle(s_mid, 24'd3, s_max - 24'd2, 16'd50, 24'd310000, 32'd700000, 32'd100);
    for (int i = 0; i < N_RANDOM; i++)
      send_particle(rand_sample(), rand_sample(), rand_sample(),
                    DIAM_W'(rand_bits(DIAM_W)), TEMP_W'(rand_bits(TEMP_W)),
                    rand_bits(VISC_W), rand_bits(DT_W));
    in_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("Sent %0d particles, checked %0d force words, %0d saturated.",
             sent, checked, n_sat);
    $display("Samples covered zero, both ends and midpoint; gaps and stalls 0 to 6 cycles.");
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // output side: random stalls, with stall-free stretches
  initial begin
    int stall, words;
    words = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = ((words / 170) % 3 == 1) ? 0 : $urandom_range(6, 0);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      words++;
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIM) begin
        $display("Timeout after %0d cycles, %0d words outstanding.", cycles, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
